// ===== rtl/hns_pkg.sv =====
// Shared constants and types for the height map normal stencil.
// Depends on nothing; every other file of the block but hns_ram imports it.
package hns_pkg;

  localparam int MESH_SIDE = 64;
  localparam int MAP_SIDE  = MESH_SIDE + 2;
  localparam int CNT_W     = $clog2(MAP_SIDE + 1);
  localparam int ADDR_W    = $clog2(MAP_SIDE);
  localparam int COORD_W   = 6;
  localparam int H_W       = 16;
  localparam int VT_W      = 15;
  localparam int VT_RESET  = 256;
  localparam int DIFF_W    = H_W + 1;
  localparam int NRM_W     = 16;
  localparam int NRMY_W    = 15;
  localparam int ONE_Q14   = 16384;
  localparam int Q_W       = 15;
  localparam int QBIT_W    = 4;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ACC_W     = 70;
  localparam int RAM_W     = 2 * H_W;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a;
    logic signed [DIFF_W-1:0] b;
    logic [VT_W-1:0]          v;
  } norm_req_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic [NRMY_W-1:0]       ny;
    logic signed [NRM_W-1:0] nz;
  } norm_res_t;

endpackage

// ===== rtl/hns_if.sv =====
// Stream interfaces for height samples in and vertices out.
// Depends on hns_pkg for the field widths.
interface hns_in_if;
  import hns_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] height;
  logic                  frame_start;
  modport source (output valid, output height, output frame_start, input ready);
  modport sink (input valid, input height, input frame_start, output ready);
endinterface

interface hns_out_if;
  import hns_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [COORD_W-1:0]      vertex_x;
  logic [COORD_W-1:0]      vertex_z;
  logic signed [H_W-1:0]   vertex_height;
  logic signed [NRM_W-1:0] normal_x;
  logic [NRMY_W-1:0]       normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    last_vertex;
  modport source (output valid, output vertex_x, output vertex_z, output vertex_height,
                  output normal_x, output normal_y, output normal_z, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_z, input vertex_height,
                input normal_x, input normal_y, input normal_z, input last_vertex,
                output ready);
endinterface

// ===== rtl/heightmap_normal_stencil.sv =====
// Top level of the height map normal stencil: counters, line store, window, output.
// Depends on hns_pkg, hns_if, hns_ram and hns_norm.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | height, frame_start
//   out_ch  | out | valid/ready        | vertex_x/z, vertex_height, normal_x/y/z, last
//   cfg     | in  | cfg_we, no stall   | cfg_wdata = vertical_term
//
// A sample that yields no vertex passes only the accept and line store access steps; one
// dropped past the end of a map leaves at accept. A vertex passes accept and line store
// access, the normalizer (squares, sum, then setup, a 15-step bit-serial search and a store
// for each of the three components) and the output load; a zero-length normal skips the rest.
// Reset is synchronous and clears counters, window, valid bits of the line store
// and the output valid bit; the line store RAM itself is not cleared, its valid bits are.
// A new transaction is taken while a finished vertex still waits on out_ch; the next
// vertex then holds in the output state until out_ch takes the waiting one.
module heightmap_normal_stencil import hns_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  hns_in_if.sink         in_ch,
  hns_out_if.source      out_ch,
  input  logic           cfg_we,
  input  logic [VT_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state_r;
  logic [VT_W-1:0]       vt_r;
  logic [CNT_W-1:0]      col_r, row_r;
  logic signed [H_W-1:0] h_r;
  logic signed [H_W-1:0] up_r;
  logic signed [H_W-1:0] w_ctr_r, w_left_r, w_down_r;
  logic [MAP_SIDE-1:0]   vld_r;

  // Vertex data that waits on the normalizer.
  logic [COORD_W-1:0]    px_r, pz_r;
  logic signed [H_W-1:0] ph_r;
  logic                  plast_r;

  // Output register.
  logic                    ov_r;
  logic [COORD_W-1:0]      ox_r, oz_r;
  logic signed [H_W-1:0]   oh_r;
  logic signed [NRM_W-1:0] onx_r, onz_r;
  logic [NRMY_W-1:0]       ony_r;
  logic                    olast_r;

  logic                  accept;
  logic                  past_end;
  logic [RAM_W-1:0]      rdata;
  logic signed [H_W-1:0] p_smp, o_smp;
  logic                  produce;
  logic                  ram_we;
  logic                  norm_start;
  logic                  norm_done;
  norm_req_t             norm_req;
  norm_res_t             norm_res;
  logic [ADDR_W-1:0]     addr;
  logic                  out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // Once a map is complete, samples are dropped until the next frame start.
  assign past_end    = !in_ch.frame_start &&
                       (row_r >= CNT_W'(MAP_SIDE) || col_r >= CNT_W'(MAP_SIDE));
  assign addr        = col_r[ADDR_W-1:0];
  // The output register takes a new vertex when it is empty or being emptied.
  assign out_load    = (state_r == ST_OUT) && (!ov_r || out_ch.ready);

  // Entry holds {older row, previous row}; an entry never written reads as zero.
  assign p_smp   = vld_r[addr] ? $signed(rdata[H_W-1:0]) : '0;
  assign o_smp   = vld_r[addr] ? $signed(rdata[RAM_W-1:H_W]) : '0;
  assign produce = (col_r >= CNT_W'(2)) && (row_r >= CNT_W'(2));
  assign ram_we  = (state_r == ST_RD);

  hns_ram #(.WIDTH(RAM_W), .DEPTH(MAP_SIDE)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({p_smp, h_r}),
    .raddr (in_ch.frame_start ? ADDR_W'(0) : addr),
    .rdata (rdata)
  );

  // Central differences: left minus right, and down (row above) minus up (this row).
  assign norm_start = (state_r == ST_RD) && produce;
  assign norm_req.a = DIFF_W'(w_left_r) - DIFF_W'(p_smp);
  assign norm_req.b = DIFF_W'(w_down_r) - DIFF_W'(up_r);
  assign norm_req.v = vt_r;

  hns_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .req   (norm_req),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vt_r     <= VT_W'(VT_RESET);
      col_r    <= '0;
      row_r    <= '0;
      up_r     <= '0;
      w_ctr_r  <= '0;
      w_left_r <= '0;
      w_down_r <= '0;
      vld_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        vt_r <= cfg_wdata;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && !past_end) begin
            h_r <= in_ch.height;
            if (in_ch.frame_start) begin
              col_r <= '0;
              row_r <= '0;
            end
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          vld_r[addr] <= 1'b1;
          w_left_r    <= w_ctr_r;
          w_ctr_r     <= p_smp;
          w_down_r    <= o_smp;
          up_r        <= h_r;
          px_r        <= COORD_W'(col_r - CNT_W'(2));
          pz_r        <= COORD_W'(row_r - CNT_W'(2));
          ph_r        <= w_ctr_r;
          plast_r     <= (col_r == CNT_W'(MAP_SIDE - 1)) && (row_r == CNT_W'(MAP_SIDE - 1));
          if (col_r == CNT_W'(MAP_SIDE - 1)) begin
            col_r <= '0;
            row_r <= row_r + CNT_W'(1);
          end else begin
            col_r <= col_r + CNT_W'(1);
          end
          state_r <= produce ? ST_NORM : ST_IDLE;
        end
        ST_NORM: begin
          if (norm_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            ox_r    <= px_r;
            oz_r    <= pz_r;
            oh_r    <= ph_r;
            onx_r   <= norm_res.nx;
            ony_r   <= norm_res.ny;
            onz_r   <= norm_res.nz;
            olast_r <= plast_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.vertex_x      = ox_r;
  assign out_ch.vertex_z      = oz_r;
  assign out_ch.vertex_height = oh_r;
  assign out_ch.normal_x      = onx_r;
  assign out_ch.normal_y      = ony_r;
  assign out_ch.normal_z      = onz_r;
  assign out_ch.last_vertex   = olast_r;

  a_norm_follows: assert property (@(posedge clk) disable iff (!rst_n)
    norm_start |=> state_r == ST_NORM)
    else $error("normalizer started but control did not wait for it");

  a_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> state_r == ST_NORM)
    else $error("normalizer finished outside the wait state");

  a_pos_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> col_r < CNT_W'(MAP_SIDE) && row_r < CNT_W'(MAP_SIDE))
    else $error("line store accessed outside the map");

endmodule

// ===== rtl/hns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module hns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 66
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hns_norm.sv =====
// Multi-cycle normalizer: squares, sum and a bit-serial search per component.
// Depends on hns_pkg.
module hns_norm import hns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  norm_req_t req,
  output logic      done,
  output norm_res_t res
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SQ    = 3'd1;
  localparam logic [2:0] N_SUM   = 3'd2;
  localparam logic [2:0] N_INIT  = 3'd3;
  localparam logic [2:0] N_ITER  = 3'd4;
  localparam logic [2:0] N_STORE = 3'd5;

  logic [2:0]              st_r;
  logic [1:0]              comp_r;
  logic [QBIT_W-1:0]       bit_r;
  logic [DIFF_W-1:0]       mag_r [3];
  logic [2:0]              neg_r;
  logic [SQ_W-1:0]         sq_r [3];
  logic [SUM_W-1:0]        s_r;
  logic signed [ACC_W-1:0] acc_r, bk_r, sk_r, t_r;
  logic [Q_W-1:0]          q_r;
  logic                    done_r;
  norm_res_t               res_r;

  logic [SQ_W-1:0]         prod;
  logic signed [ACC_W-1:0] s_ext, sq_ext, trial;
  logic [Q_W-1:0]          qc;
  logic signed [NRM_W-1:0] qs;
  logic                    sq_zero;

  assign prod    = SQ_W'(mag_r[comp_r]) * SQ_W'(mag_r[comp_r]);
  assign s_ext   = ACC_W'(s_r);
  assign sq_ext  = ACC_W'(sq_r[comp_r]);
  assign trial   = acc_r + bk_r + sk_r;
  assign qc      = (q_r > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_r;
  assign qs      = neg_r[comp_r] ? -$signed(NRM_W'(qc)) : $signed(NRM_W'(qc));
  assign sq_zero = (sq_r[0] | sq_r[1] | sq_r[2]) == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
      comp_r <= '0;
      bit_r  <= '0;
    end else begin
      done_r <= ((st_r == N_SUM) && sq_zero) || ((st_r == N_STORE) && (comp_r == 2'd2));
      case (st_r)
        N_IDLE: begin
          if (start) begin
            mag_r[0] <= req.a[DIFF_W-1] ? DIFF_W'(-req.a) : DIFF_W'(req.a);
            mag_r[1] <= DIFF_W'(req.v);
            mag_r[2] <= req.b[DIFF_W-1] ? DIFF_W'(-req.b) : DIFF_W'(req.b);
            neg_r    <= {req.b[DIFF_W-1], 1'b0, req.a[DIFF_W-1]};
            comp_r   <= '0;
            st_r     <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r[comp_r] <= prod;
          if (comp_r == 2'd2) begin
            st_r <= N_SUM;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        N_SUM: begin
          s_r    <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
          comp_r <= '0;
          if (sq_zero) begin
            // Degenerate vector: straight up.
            res_r.nx <= '0;
            res_r.ny <= NRMY_W'(ONE_Q14);
            res_r.nz <= '0;
            st_r     <= N_IDLE;
          end else begin
            st_r <= N_INIT;
          end
        end
        N_INIT: begin
          // Search state for candidate m: acc = (2q-1)^2*s, bk = (2q-1)*s << (k+2),
          // sk = s << (2k+2), against t = c^2 << 30.
          acc_r <= s_ext;
          bk_r  <= -(s_ext <<< 16);
          sk_r  <= s_ext <<< 30;
          t_r   <= sq_ext <<< 30;
          q_r   <= '0;
          bit_r <= QBIT_W'(Q_W - 1);
          st_r  <= N_ITER;
        end
        N_ITER: begin
          if (trial <= t_r) begin
            q_r   <= q_r | (Q_W'(1) << bit_r);
            acc_r <= trial;
            bk_r  <= (bk_r >>> 1) + sk_r;
          end else begin
            bk_r <= bk_r >>> 1;
          end
          sk_r <= sk_r >>> 2;
          if (bit_r == '0) begin
            st_r <= N_STORE;
          end else begin
            bit_r <= bit_r - QBIT_W'(1);
          end
        end
        N_STORE: begin
          case (comp_r)
            2'd0:    res_r.nx <= qs;
            2'd1:    res_r.ny <= qc;
            default: res_r.nz <= qs;
          endcase
          if (comp_r == 2'd2) begin
            st_r <= N_IDLE;
          end else begin
            comp_r <= comp_r + 2'd1;
            st_r   <= N_INIT;
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== dv/hns_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench copy note: the block's stream interfaces live in rtl/hns_if.sv.
// This file holds a small helper package of verification types; depends on hns_pkg.
package hns_tb_pkg;
  import hns_pkg::*;

  typedef struct {
    logic [COORD_W-1:0]      vx;
    logic [COORD_W-1:0]      vz;
    logic signed [H_W-1:0]   vh;
    logic signed [NRM_W-1:0] nx;
    logic [NRMY_W-1:0]       ny;
    logic signed [NRM_W-1:0] nz;
    logic                    last;
  } vertex_t;
endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heightmap_normal_stencil: streams height maps, predicts
// each vertex and its normal, compares every vertex. Depends on hns_pkg, hns_if, hns_tb_pkg.
module tb import hns_pkg::*, hns_tb_pkg::*; ();

  localparam int LIMIT   = 1000000;
  // Samples per map: the two border rows and a little over one row of vertices.
  localparam int MAP_LEN = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [VT_W-1:0] cfg_wdata = '0;

  hns_in_if  in_ch ();
  hns_out_if out_ch ();

  heightmap_normal_stencil i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors the line stores, counters and window of the block.
  logic [VT_W-1:0]    vterm;
  logic [H_W-1:0]     prev_row [MAP_SIDE];
  logic [H_W-1:0]     older_row [MAP_SIDE];
  int                 col, row;
  logic [H_W-1:0]     win [3];
  vertex_t            pending_vertices [$];
  int                 errors = 0;
  int                 vertices_seen = 0;
  int                 samples_sent = 0;
  longint             cycles = 0;

  function automatic void clear_model();
    vterm = VT_W'(VT_RESET);
    col = 0;
    row = 0;
    foreach (prev_row[i]) begin
      prev_row[i] = '0;
      older_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
  endfunction

  // Largest q with (2q-1)^2 * s <= mag^2 * 2^30, i.e. round-half-up of mag*16384/sqrt(s).
  function automatic int unsigned scale_q14(longint unsigned mag, longint unsigned s);
    longint unsigned lo, hi, mid, t, goal;
    goal = (mag * mag) << 30;
    lo = 0;
    hi = ONE_Q14;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= goal) lo = mid;
      else hi = mid - 1;
    end
    return 32'(lo);
  endfunction

  function automatic int signed_q14(longint c, longint unsigned s);
    int q;
    q = scale_q14(c < 0 ? -c : c, s);
    return c < 0 ? -q : q;
  endfunction

  // Advance the stencil by one sample; returns 1 and fills v when a vertex is due.
  function automatic bit stencil_step(logic [H_W-1:0] h, bit fs, output vertex_t v);
    logic [H_W-1:0] p, o;
    longint a, b, vv;
    longint unsigned s;
    bit got;
    got = 0;
    v = '{default: '0};
    if (fs) begin
      col = 0;
      row = 0;
    end
    if (row >= MAP_SIDE || col >= MAP_SIDE) return 0;
    p = prev_row[col];
    o = older_row[col];
    if (col >= 2 && row >= 2) begin
      a = longint'($signed(win[1])) - longint'($signed(p));
      b = longint'($signed(win[2])) - longint'($signed(prev_row[col-1]));
      vv = vterm;
      s = a * a + vv * vv + b * b;
      v.vx = COORD_W'(col - 2);
      v.vz = COORD_W'(row - 2);
      v.vh = win[0];
      if (s == 0) begin
        v.nx = '0;
        v.ny = NRMY_W'(ONE_Q14);
        v.nz = '0;
      end else begin
        v.nx = NRM_W'(signed_q14(a, s));
        v.ny = NRMY_W'(scale_q14(vv, s));
        v.nz = NRM_W'(signed_q14(b, s));
      end
      v.last = (col == MAP_SIDE - 1 && row == MAP_SIDE - 1);
      got = 1;
    end
    win[1] = win[0];
    win[0] = p;
    win[2] = o;
    older_row[col] = p;
    prev_row[col] = h;
    col++;
    if (col >= MAP_SIDE) begin
      col = 0;
      row++;
    end
    return got;
  endfunction

  // Sender side. Inputs change on the falling edge; the transaction counts at the
  // next rising edge with ready high.
  task automatic send_sample(logic [H_W-1:0] h, bit fs, int gap);
    vertex_t v;
    repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.height <= h;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    if (stencil_step(h, fs, v)) pending_vertices.push_back(v);
    samples_sent++;
    // Valid is only lowered by the next call's gap or at the end, so no double drive.
    if (gap == 0) ;
  endtask

  task automatic end_burst();
    @(negedge clk) in_ch.valid <= 1'b0;
  endtask

  int max_gap = 17;
  function automatic int draw_gap();
    return max_gap == 0 ? 0 : $urandom_range(0, max_gap);
  endfunction

  // Waits until every predicted vertex has come, then lets the block drain.
  task automatic drain();
    end_burst();
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_vterm(logic [VT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    vterm = val;
  endtask

  // Sends the start of one map (border rows and the first row of vertices);
  // mode 0 random heights, 1 extremes, 2 small slopes, 3 flat.
  task automatic send_map(int mode);
    logic [H_W-1:0] h;
    for (int i = 0; i < MAP_LEN; i++) begin
      case (mode)
        0: h = 16'($urandom());
        1: h = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        2: h = 16'(i % MAP_SIDE) * 16'($urandom_range(0, 40)) - 16'd800;
        default: h = 16'h0100;
      endcase
      send_sample(h, i == 0, draw_gap());
    end
  endtask

  // Receiver side: random stalls after each vertex, comparison at the rising edge.
  int stall_left = 0;
  bit out_taken = 1'b0;
  always @(negedge clk) begin
    if (out_taken) stall_left = draw_gap();
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    cycles <= cycles + 1;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (out_taken) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        $display("%0t: vertex with nothing expected (x=%0d z=%0d)", $time,
                 out_ch.vertex_x, out_ch.vertex_z);
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (out_ch.vertex_x !== e.vx || out_ch.vertex_z !== e.vz ||
            out_ch.vertex_height !== e.vh || out_ch.normal_x !== e.nx ||
            out_ch.normal_y !== e.ny || out_ch.normal_z !== e.nz ||
            out_ch.last_vertex !== e.last) begin
          $display("%0t: mismatch expected x=%0d z=%0d h=%0d n=(%0d,%0d,%0d) last=%0b",
                   $time, e.vx, e.vz, e.vh, e.nx, e.ny, e.nz, e.last);
          $display("%0t:          actual x=%0d z=%0d h=%0d n=(%0d,%0d,%0d) last=%0b",
                   $time, out_ch.vertex_x, out_ch.vertex_z, out_ch.vertex_height,
                   out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.last_vertex);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d vertices pending", $time, pending_vertices.size());
      $display("[heightmap_normal_stencil] ERROR");
      $finish;
    end
  end

  // Directed stimulus: a short stream after reset. It stays in the border rows, so it
  // gives no vertex; it covers extremes, a missing first frame_start and a restart.
  typedef struct {
    logic [H_W-1:0] h;
    bit             fs;
  } sample_row_t;

  sample_row_t directed [10] = '{
    '{16'h8000, 1'b0}, '{16'h7fff, 1'b0}, '{16'h0000, 1'b0}, '{16'hffff, 1'b0},
    '{16'h0001, 1'b1}, '{16'h7fff, 1'b0}, '{16'h8000, 1'b0}, '{16'h5555, 1'b0},
    '{16'haaaa, 1'b0}, '{16'h0100, 1'b1}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.height = '0;
    in_ch.frame_start = 1'b0;
    clear_model();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part: border samples, a missing first frame_start and a mid-map restart.
    max_gap = 0;
    foreach (directed[i]) send_sample(directed[i].h, directed[i].fs, 0);
    drain();

    // Flat map with the reset vertical term, then extremes under the largest term.
    send_map(3);
    drain();
    write_vterm(15'h7fff);
    send_map(1);
    drain();
    // Zero term with flat ground hits the zero-length special case.
    write_vterm(15'd0);
    send_map(3);
    drain();
    write_vterm(15'd1);
    send_map(1);
    drain();

    // Random maps with random idling on both sides.
    max_gap = 17;
    for (int m = 0; m < 6; m++) begin
      write_vterm(m == 5 ? 15'd256 : 15'($urandom_range(1, 32767)));
      send_map(m % 3);
      // The sender holds off until everything expected has arrived.
      drain();
    end

    $display("Run sent %0d samples and checked %0d vertices: border rows, restarts,",
             samples_sent, vertices_seen);
    $display("extreme slopes, the zero-length normal and random maps with idling.");
    if (errors == 0) begin
      $display("[heightmap_normal_stencil] OK");
    end else begin
      $display("[heightmap_normal_stencil] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/hns_pkg.sv
rtl/hns_if.sv
rtl/hns_ram.sv
rtl/hns_norm.sv
rtl/heightmap_normal_stencil.sv
dv/hns_tb_if.sv
dv/tb.sv
